/* rtl/aabb_point_range_query_assert.svh */
// Assertion macros shared by the box query block.
// Needs only the clock and reset names that the caller passes in.
`ifndef AABB_POINT_RANGE_QUERY_ASSERT_SVH
`define AABB_POINT_RANGE_QUERY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define APRQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define APRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/aprq_pkg.sv */
// Package for the box range query block: sizes, codes and shared types.
// No dependencies; the files that use it refer to it by scoped names.
package aprq_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 32;
  localparam int ID_BITS    = 16;
  localparam int HALF_BITS  = COORD_BITS - 1;
  localparam int EXT_BITS   = COORD_BITS + 1;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_NOHIT    = 3'd1,
    ST_INSERTED = 3'd2,
    ST_FULL     = 3'd3,
    ST_DUP      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } state_t;

  // One stored entry. Coordinates are kept as raw two's complement bits.
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
    logic [ID_BITS-1:0]    id;
  } point_t;

  // Query box bounds, one bit wider than a coordinate so they never overflow.
  typedef struct packed {
    logic [EXT_BITS-1:0] lo_x;
    logic [EXT_BITS-1:0] hi_x;
    logic [EXT_BITS-1:0] lo_y;
    logic [EXT_BITS-1:0] hi_y;
    logic [EXT_BITS-1:0] lo_z;
    logic [EXT_BITS-1:0] hi_z;
  } bounds_t;

  typedef struct packed {
    logic in_box;
    logic id_eq;
    logic id_lt;
  } cmp_res_t;

endpackage

/* rtl/aprq_if.sv */
// Channel interfaces of the box range query block: input and result.
// Depends on aprq_pkg for the field widths and codes.
interface aprq_in_if;
  logic                                  valid;
  logic                                  ready;
  aprq_pkg::cmd_t                        command;
  logic signed [aprq_pkg::COORD_BITS-1:0] coord_x;
  logic signed [aprq_pkg::COORD_BITS-1:0] coord_y;
  logic signed [aprq_pkg::COORD_BITS-1:0] coord_z;
  logic [aprq_pkg::HALF_BITS-1:0]        half_width;
  logic [aprq_pkg::ID_BITS-1:0]          point_id;

  modport source (output valid, command, coord_x, coord_y, coord_z, half_width, point_id,
                  input ready);
  modport sink   (input valid, command, coord_x, coord_y, coord_z, half_width, point_id,
                  output ready);
endinterface

interface aprq_out_if;
  logic                         valid;
  logic                         ready;
  logic [aprq_pkg::ID_BITS-1:0] hit_id;
  aprq_pkg::status_t            status;
  logic                         last;

  modport source (output valid, hit_id, status, last, input ready);
  modport sink   (input valid, hit_id, status, last, output ready);
endinterface

/* rtl/aprq_ram.sv */
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module aprq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 112
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/aprq_cmp.sv */
// Shared compare unit: tests one stored entry against the query box and
// against the index of a point being inserted. Depends on aprq_pkg.
module aprq_cmp (
  input  aprq_pkg::point_t            entry,
  input  aprq_pkg::bounds_t           bounds,
  input  logic [aprq_pkg::ID_BITS-1:0] key_id,
  output aprq_pkg::cmp_res_t          res
);

  logic signed [aprq_pkg::EXT_BITS-1:0] px;
  logic signed [aprq_pkg::EXT_BITS-1:0] py;
  logic signed [aprq_pkg::EXT_BITS-1:0] pz;
  logic                                 in_x;
  logic                                 in_y;
  logic                                 in_z;

  assign px = {entry.x[aprq_pkg::COORD_BITS-1], entry.x};
  assign py = {entry.y[aprq_pkg::COORD_BITS-1], entry.y};
  assign pz = {entry.z[aprq_pkg::COORD_BITS-1], entry.z};

  // Half-open range on each axis: low bound included, high bound excluded.
  assign in_x = (px >= $signed(bounds.lo_x)) && (px < $signed(bounds.hi_x));
  assign in_y = (py >= $signed(bounds.lo_y)) && (py < $signed(bounds.hi_y));
  assign in_z = (pz >= $signed(bounds.lo_z)) && (pz < $signed(bounds.hi_z));

  assign res.in_box = in_x && in_y && in_z;
  assign res.id_eq  = (entry.id == key_id);
  assign res.id_lt  = (entry.id < key_id);

endmodule

/* rtl/aabb_point_range_query.sv */
// Top level of the box range query block: sequencer, store and result register.
// Depends on aprq_pkg, aprq_if, aprq_ram, aprq_cmp and the assertion header.
//
//  channel   | dir | handshake            | payload
//  in_chan   | in  | valid/ready          | command, coord_x/y/z, half_width, point_id
//  out_chan  | out | valid/ready          | hit_id, status, last
//
// The store stays sorted by point index, so a query emits its hits in one pass.
// A query scans every stored entry and then registers its final result; an insert
// that is stored scans too, moves the entries from sorted slot p up by one (none if
// p = n) and writes the point to slot p before its final result is registered.
// Input is ready again once the final result is registered. Reset (synchronous, active low) empties the store.
// A full result register stalls the scan and the final result; nothing else waits.
`include "aabb_point_range_query_assert.svh"

module aabb_point_range_query (
  input logic       clk,
  input logic       rst_n,
  aprq_in_if.sink   in_chan,
  aprq_out_if.source out_chan
);

  localparam int PW = $bits(aprq_pkg::point_t);

  aprq_pkg::state_t   state_r, state_nxt;
  aprq_pkg::cmd_t     cmd_r;
  aprq_pkg::point_t   new_pt_r;
  aprq_pkg::bounds_t  bounds_r;
  aprq_pkg::status_t  fin_st_r, fin_st_nxt;
  logic [aprq_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [aprq_pkg::CNT_W-1:0]   iss_r, iss_nxt;
  logic [aprq_pkg::CNT_W-1:0]   proc_r, proc_nxt;
  logic [aprq_pkg::CNT_W-1:0]   pos_r, pos_nxt;
  logic                         dup_r, dup_nxt;
  logic                         pend_vld_r, pend_vld_nxt;
  logic [aprq_pkg::ID_BITS-1:0] pend_id_r, pend_id_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [aprq_pkg::ADDR_W-1:0]  rd_addr_r;

  logic                         out_vld_r, out_vld_nxt;
  logic [aprq_pkg::ID_BITS-1:0] out_id_r;
  aprq_pkg::status_t            out_st_r;
  logic                         out_last_r;

  logic                         in_acc;
  logic                         can_push;
  logic                         scan_end;
  logic                         shift_end;
  logic                         consume;
  logic                         ren;
  logic [aprq_pkg::ADDR_W-1:0]  raddr;
  logic                         we;
  logic [aprq_pkg::ADDR_W-1:0]  waddr;
  aprq_pkg::point_t             wdata;
  logic [PW-1:0]                rdata_raw;
  aprq_pkg::point_t             rdata;
  aprq_pkg::cmp_res_t           cmp;
  logic                         push;
  logic [aprq_pkg::ID_BITS-1:0] push_id;
  aprq_pkg::status_t            push_st;
  logic                         push_last;
  logic signed [aprq_pkg::EXT_BITS-1:0] cx;
  logic signed [aprq_pkg::EXT_BITS-1:0] cy;
  logic signed [aprq_pkg::EXT_BITS-1:0] cz;
  logic signed [aprq_pkg::EXT_BITS-1:0] dd;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign can_push = !out_vld_r || out_chan.ready;
  assign scan_end  = (proc_r == cnt_r);
  assign shift_end = (iss_r == pos_r) && !rd_vld_r;
  assign rdata     = aprq_pkg::point_t'(rdata_raw);

  assign in_chan.ready   = (state_r == aprq_pkg::S_IDLE);
  assign out_chan.valid  = out_vld_r;
  assign out_chan.hit_id = out_id_r;
  assign out_chan.status = out_st_r;
  assign out_chan.last   = out_last_r;

  assign cx = {in_chan.coord_x[aprq_pkg::COORD_BITS-1], in_chan.coord_x};
  assign cy = {in_chan.coord_y[aprq_pkg::COORD_BITS-1], in_chan.coord_y};
  assign cz = {in_chan.coord_z[aprq_pkg::COORD_BITS-1], in_chan.coord_z};
  assign dd = {2'b00, in_chan.half_width};

  aprq_ram #(
    .DEPTH (aprq_pkg::MAX_POINTS),
    .WIDTH (PW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ren),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  aprq_cmp u_cmp (
    .entry  (rdata),
    .bounds (bounds_r),
    .key_id (new_pt_r.id),
    .res    (cmp)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aprq_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = aprq_pkg::S_SCAN;
        end
      end
      aprq_pkg::S_SCAN: begin
        if (scan_end) begin
          if (cmd_r == aprq_pkg::CMD_QUERY || dup_r ||
              cnt_r == aprq_pkg::CNT_W'(aprq_pkg::MAX_POINTS)) begin
            state_nxt = aprq_pkg::S_DONE;
          end else begin
            state_nxt = aprq_pkg::S_SHIFT;
          end
        end
      end
      aprq_pkg::S_SHIFT: begin
        if (shift_end) begin
          state_nxt = aprq_pkg::S_WRITE;
        end
      end
      aprq_pkg::S_WRITE: state_nxt = aprq_pkg::S_DONE;
      aprq_pkg::S_DONE: begin
        if (can_push) begin
          state_nxt = aprq_pkg::S_IDLE;
        end
      end
      default: state_nxt = aprq_pkg::S_IDLE;
    endcase
  end

  // Control outputs: memory ports and result pushes.
  always_comb begin
    ren       = 1'b0;
    raddr     = iss_r[aprq_pkg::ADDR_W-1:0];
    consume   = 1'b0;
    we        = 1'b0;
    waddr     = rd_addr_r + aprq_pkg::ADDR_W'(1);
    wdata     = rdata;
    push      = 1'b0;
    push_id   = pend_id_r;
    push_st   = aprq_pkg::ST_HIT;
    push_last = 1'b0;
    case (state_r)
      aprq_pkg::S_SCAN: begin
        ren     = can_push && (iss_r < cnt_r);
        consume = rd_vld_r && can_push;
        // A new hit releases the one held before it, which is then known not to be last.
        if (consume && cmd_r == aprq_pkg::CMD_QUERY && cmp.in_box && pend_vld_r) begin
          push = 1'b1;
        end
      end
      aprq_pkg::S_SHIFT: begin
        ren     = (iss_r > pos_r);
        raddr   = aprq_pkg::ADDR_W'(iss_r - aprq_pkg::CNT_W'(1));
        consume = rd_vld_r;
        we      = rd_vld_r;
      end
      aprq_pkg::S_WRITE: begin
        we    = 1'b1;
        waddr = pos_r[aprq_pkg::ADDR_W-1:0];
        wdata = new_pt_r;
      end
      aprq_pkg::S_DONE: begin
        push      = can_push;
        push_st   = fin_st_r;
        push_last = 1'b1;
        push_id   = (fin_st_r == aprq_pkg::ST_HIT) ? pend_id_r : '0;
      end
      default: begin
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    cnt_nxt      = cnt_r;
    iss_nxt      = iss_r;
    proc_nxt     = proc_r;
    pos_nxt      = pos_r;
    dup_nxt      = dup_r;
    pend_vld_nxt = pend_vld_r;
    pend_id_nxt  = pend_id_r;
    fin_st_nxt   = fin_st_r;
    rd_vld_nxt   = ren ? 1'b1 : (consume ? 1'b0 : rd_vld_r);
    out_vld_nxt  = push ? 1'b1 : (out_chan.ready ? 1'b0 : out_vld_r);

    if (in_acc) begin
      iss_nxt      = '0;
      proc_nxt     = '0;
      pos_nxt      = '0;
      dup_nxt      = 1'b0;
      pend_vld_nxt = 1'b0;
    end

    if (state_r == aprq_pkg::S_SCAN) begin
      if (ren) begin
        iss_nxt = iss_r + aprq_pkg::CNT_W'(1);
      end
      if (consume) begin
        proc_nxt = proc_r + aprq_pkg::CNT_W'(1);
        if (cmd_r == aprq_pkg::CMD_QUERY) begin
          if (cmp.in_box) begin
            pend_vld_nxt = 1'b1;
            pend_id_nxt  = rdata.id;
          end
        end else begin
          if (cmp.id_eq) begin
            dup_nxt = 1'b1;
          end
          if (cmp.id_lt) begin
            pos_nxt = pos_r + aprq_pkg::CNT_W'(1);
          end
        end
      end
      if (scan_end) begin
        if (cmd_r == aprq_pkg::CMD_QUERY) begin
          fin_st_nxt = pend_vld_r ? aprq_pkg::ST_HIT : aprq_pkg::ST_NOHIT;
        end else if (dup_r) begin
          fin_st_nxt = aprq_pkg::ST_DUP;
        end else if (cnt_r == aprq_pkg::CNT_W'(aprq_pkg::MAX_POINTS)) begin
          fin_st_nxt = aprq_pkg::ST_FULL;
        end else begin
          fin_st_nxt = aprq_pkg::ST_INSERTED;
        end
      end
    end

    if (state_r == aprq_pkg::S_SHIFT && ren) begin
      iss_nxt = iss_r - aprq_pkg::CNT_W'(1);
    end

    if (state_r == aprq_pkg::S_WRITE) begin
      cnt_nxt = cnt_r + aprq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= aprq_pkg::S_IDLE;
      cnt_r      <= '0;
      rd_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      rd_vld_r   <= rd_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r     <= iss_nxt;
    proc_r    <= proc_nxt;
    pos_r     <= pos_nxt;
    dup_r     <= dup_nxt;
    pend_id_r <= pend_id_nxt;
    fin_st_r  <= fin_st_nxt;
    if (ren) begin
      rd_addr_r <= raddr;
    end
    if (in_acc) begin
      cmd_r       <= in_chan.command;
      new_pt_r.x  <= in_chan.coord_x;
      new_pt_r.y  <= in_chan.coord_y;
      new_pt_r.z  <= in_chan.coord_z;
      new_pt_r.id <= in_chan.point_id;
      bounds_r.lo_x <= cx - dd;
      bounds_r.hi_x <= cx + dd;
      bounds_r.lo_y <= cy - dd;
      bounds_r.hi_y <= cy + dd;
      bounds_r.lo_z <= cz - dd;
      bounds_r.hi_z <= cz + dd;
    end
    if (push) begin
      out_id_r   <= push_id;
      out_st_r   <= push_st;
      out_last_r <= push_last;
    end
  end

  `APRQ_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1,
    cnt_r <= aprq_pkg::CNT_W'(aprq_pkg::MAX_POINTS), "point count above store size")
  `APRQ_ASSERT_NEXT(a_cnt_only_on_write, clk, rst_n, state_r != aprq_pkg::S_WRITE,
    $stable(cnt_r), "point count changed outside a store write")
  `APRQ_ASSERT_NOW(a_rd_in_walk, clk, rst_n, rd_vld_r,
    state_r == aprq_pkg::S_SCAN || state_r == aprq_pkg::S_SHIFT,
    "read data pending outside a memory walk")
  `APRQ_ASSERT_NOW(a_early_only_in_scan, clk, rst_n, push && !push_last,
    state_r == aprq_pkg::S_SCAN && cmd_r == aprq_pkg::CMD_QUERY,
    "non-final result outside a query scan")

endmodule

/* tb/sv/aabb_point_range_query_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for aabb_point_range_query: inserts and box queries.
// It mirrors the point store to predict every reply and checks the result channel.
// Depends on aprq_pkg, the aprq_in_if / aprq_out_if interfaces and the block itself.
module aabb_point_range_query_test;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int TAIL_ITEMS = 20;
  localparam int HOLD_AT = 140;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 165;

  typedef struct {
    aprq_pkg::cmd_t                         cmd;
    logic signed [aprq_pkg::COORD_BITS-1:0] x;
    logic signed [aprq_pkg::COORD_BITS-1:0] y;
    logic signed [aprq_pkg::COORD_BITS-1:0] z;
    logic [aprq_pkg::HALF_BITS-1:0]         hw;
    logic [aprq_pkg::ID_BITS-1:0]           id;
    bit                                     drain;
  } cmd_item_t;

  typedef struct {
    logic [aprq_pkg::ID_BITS-1:0] id;
    aprq_pkg::status_t            status;
    logic                         last;
  } reply_t;

  logic clk;
  logic rst_n;

  aprq_in_if  in_if();
  aprq_out_if out_if();

  aabb_point_range_query i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Mirror of the point store, in insertion order.
  logic signed [aprq_pkg::COORD_BITS-1:0] mirror_x[aprq_pkg::MAX_POINTS];
  logic signed [aprq_pkg::COORD_BITS-1:0] mirror_y[aprq_pkg::MAX_POINTS];
  logic signed [aprq_pkg::COORD_BITS-1:0] mirror_z[aprq_pkg::MAX_POINTS];
  logic [aprq_pkg::ID_BITS-1:0]           mirror_id[aprq_pkg::MAX_POINTS];
  int                                     mirror_count = 0;

  cmd_item_t commands_to_send[$];
  reply_t    awaited_replies[$];

  // Points already handed to the stimulus, used to aim queries at occupied space.
  logic [aprq_pkg::COORD_BITS-1:0] placed_x[$];
  logic [aprq_pkg::COORD_BITS-1:0] placed_y[$];
  logic [aprq_pkg::COORD_BITS-1:0] placed_z[$];
  logic [aprq_pkg::ID_BITS-1:0]    placed_id[$];

  int        item_total = 0;
  int        sent_count = 0;
  int        fail_count = 0;
  int        cycle_count = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        hold_left = 0;
  bit        hold_done = 0;
  bit        took;
  bit        tail;
  bit        calm;
  cmd_item_t on_bus;
  reply_t    want;

  always #5 clk = ~clk;

  function automatic void owe_reply(logic [aprq_pkg::ID_BITS-1:0] id,
                                    aprq_pkg::status_t st, logic last);
    reply_t r;
    r.id = id;
    r.status = st;
    r.last = last;
    awaited_replies = {awaited_replies, r};
  endfunction

  // Half-open test c - d <= p < c + d, done two bits wider so nothing wraps.
  function automatic bit on_axis(logic signed [aprq_pkg::COORD_BITS-1:0] p,
                                 logic signed [aprq_pkg::COORD_BITS-1:0] c,
                                 logic [aprq_pkg::HALF_BITS-1:0] d);
    logic signed [aprq_pkg::COORD_BITS+1:0] pw;
    logic signed [aprq_pkg::COORD_BITS+1:0] cw;
    logic signed [aprq_pkg::COORD_BITS+1:0] dw;
    pw = (aprq_pkg::COORD_BITS+2)'(p);
    cw = (aprq_pkg::COORD_BITS+2)'(c);
    dw = {3'b000, d};
    return (pw >= cw - dw) && (pw < cw + dw);
  endfunction

  function automatic void answer_command(cmd_item_t it);
    logic [aprq_pkg::ID_BITS-1:0] found[$];
    logic [aprq_pkg::ID_BITS-1:0] swap_id;
    bit                           dup;
    int                           k;
    dup = 0;
    if (it.cmd == aprq_pkg::CMD_INSERT) begin
      for (int i = 0; i < mirror_count; i++)
        if (mirror_id[i] == it.id) dup = 1;
      // The duplicate check wins over the full check.
      if (dup) begin
        owe_reply('0, aprq_pkg::ST_DUP, 1'b1);
      end else if (mirror_count >= aprq_pkg::MAX_POINTS) begin
        owe_reply('0, aprq_pkg::ST_FULL, 1'b1);
      end else begin
        mirror_x[mirror_count] = it.x;
        mirror_y[mirror_count] = it.y;
        mirror_z[mirror_count] = it.z;
        mirror_id[mirror_count] = it.id;
        mirror_count++;
        owe_reply('0, aprq_pkg::ST_INSERTED, 1'b1);
      end
    end else begin
      for (int i = 0; i < mirror_count; i++) begin
        if (on_axis(mirror_x[i], it.x, it.hw) && on_axis(mirror_y[i], it.y, it.hw) &&
            on_axis(mirror_z[i], it.z, it.hw)) begin
          found = {found, mirror_id[i]};
          k = found.size() - 1;
          while (k > 0 && found[k-1] > found[k]) begin
            swap_id = found[k-1];
            found[k-1] = found[k];
            found[k] = swap_id;
            k--;
          end
        end
      end
      if (found.size() == 0) begin
        owe_reply('0, aprq_pkg::ST_NOHIT, 1'b1);
      end else begin
        for (int i = 0; i < found.size(); i++)
          owe_reply(found[i], aprq_pkg::ST_HIT, i == found.size() - 1);
      end
    end
  endfunction

  function automatic void add_insert(logic [aprq_pkg::COORD_BITS-1:0] x,
                                     logic [aprq_pkg::COORD_BITS-1:0] y,
                                     logic [aprq_pkg::COORD_BITS-1:0] z,
                                     logic [aprq_pkg::ID_BITS-1:0] id,
                                     bit drain);
    cmd_item_t it;
    it.cmd = aprq_pkg::CMD_INSERT;
    it.x = x;
    it.y = y;
    it.z = z;
    it.hw = aprq_pkg::HALF_BITS'($urandom);
    it.id = id;
    it.drain = drain;
    commands_to_send = {commands_to_send, it};
    placed_x = {placed_x, x};
    placed_y = {placed_y, y};
    placed_z = {placed_z, z};
    placed_id = {placed_id, id};
  endfunction

  function automatic void add_query(logic [aprq_pkg::COORD_BITS-1:0] x,
                                    logic [aprq_pkg::COORD_BITS-1:0] y,
                                    logic [aprq_pkg::COORD_BITS-1:0] z,
                                    logic [aprq_pkg::HALF_BITS-1:0] hw,
                                    bit drain);
    cmd_item_t it;
    it.cmd = aprq_pkg::CMD_QUERY;
    it.x = x;
    it.y = y;
    it.z = z;
    it.hw = hw;
    it.id = aprq_pkg::ID_BITS'($urandom);
    it.drain = drain;
    commands_to_send = {commands_to_send, it};
  endfunction

  function automatic logic [aprq_pkg::COORD_BITS-1:0] near(
      logic [aprq_pkg::COORD_BITS-1:0] c, int unsigned spread);
    return c + $urandom_range(0, 2 * spread) - spread;
  endfunction

  // Input side: offers queued commands, idles in bursts, and predicts on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      took = in_if.valid && in_if.ready;
      tail = sent_count + TAIL_ITEMS >= item_total;
      calm = ((sent_count / 30) % 4) == 3;
      if (took) begin
        answer_command(on_bus);
        sent_count <= sent_count + 1;
      end
      if (in_if.valid && !took) begin
        // Hold the current transaction until it is taken.
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (commands_to_send.size() != 0 &&
                   (!commands_to_send[0].drain || awaited_replies.size() == 0)) begin
        on_bus = commands_to_send.pop_front();
        in_if.command <= on_bus.cmd;
        in_if.coord_x <= on_bus.x;
        in_if.coord_y <= on_bus.y;
        in_if.coord_z <= on_bus.z;
        in_if.half_width <= on_bus.hw;
        in_if.point_id <= on_bus.id;
        in_if.valid <= 1'b1;
        if (!tail && !calm && $urandom_range(0, 5) == 0)
          gap_left <= $urandom_range(1, 18);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // One long hold-off of the result side, so the block backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_count == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (sent_count + TAIL_ITEMS < item_total && ((sent_count / 30) % 4) != 3 &&
                 $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Result side: every transaction is matched against the oldest awaited reply.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result hit_id %0d status %0d last %0d", $time,
                 out_if.hit_id, out_if.status, out_if.last);
        fail_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (out_if.hit_id !== want.id) begin
          $display("%0t: hit_id expected %0d actual %0d", $time, want.id, out_if.hit_id);
          fail_count++;
        end
        if (out_if.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_if.status);
          fail_count++;
        end
        if (out_if.last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_if.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [aprq_pkg::COORD_BITS-1:0] base[3];
    logic [aprq_pkg::COORD_BITS-1:0] cx;
    logic [aprq_pkg::COORD_BITS-1:0] cy;
    logic [aprq_pkg::COORD_BITS-1:0] cz;
    logic [aprq_pkg::ID_BITS-1:0]    nid;
    int                              roll;
    int                              pick;
    int                              b;
    bit                              drain;

    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = aprq_pkg::CMD_INSERT;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    in_if.coord_z = '0;
    in_if.half_width = '0;
    in_if.point_id = '0;
    out_if.ready = 1'b0;

    base[0] = 32'h0000_0000;
    base[1] = 32'h1234_0000;
    base[2] = 32'hAB00_0000;

    // Directed part: empty store, coordinate and index extremes, duplicates,
    // empty boxes, both edges of the half-open range and ordering of several hits.
    add_query(32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF, 1'b0);
    add_insert(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000, 1'b0);
    add_insert(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
    add_insert(32'h0, 32'h0, 32'h0, 16'd1234, 1'b0);
    add_insert(32'h0, 32'h0, 32'h0, 16'h0000, 1'b0);
    add_insert(32'h5555_AAAA, 32'hAAAA_5555, 32'h0F0F_F0F0, 16'hFFFF, 1'b1);
    add_query(32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF, 1'b0);
    add_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd1, 1'b0);
    add_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1, 1'b0);
    add_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0, 1'b0);
    add_query(32'h0, 32'h0, 32'h0, 31'd0, 1'b0);
    add_insert(32'h0001_0000, 32'h0, 32'h0, 16'd7, 1'b0);
    add_query(32'h0, 32'h0, 32'h0, 31'h0001_0000, 1'b0);
    add_query(32'h0001_0000, 32'h0, 32'h0, 31'h0001_0000, 1'b0);
    add_insert(32'hFFFF_0000, 32'h0, 32'h0, 16'd3, 1'b0);
    add_query(32'h0, 32'h0, 32'h0, 31'h0001_0000, 1'b1);
    add_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0);
    add_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    add_query(32'hFFFF_FFFF, 32'h0, 32'h0, 31'd1, 1'b0);

    // Random part: clustered points so that queries hit several entries, enough
    // inserts to fill the store, and some wide-open or fully random traffic.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      drain = (n == 60) || (n == 130);
      b = $urandom_range(0, 2);
      if (roll < 50) begin
        if (roll < 6) begin
          pick = $urandom_range(0, placed_id.size() - 1);
          nid = placed_id[pick];
        end else begin
          nid = aprq_pkg::ID_BITS'($urandom);
        end
        if ($urandom_range(0, 3) == 0) begin
          cx = $urandom;
          cy = $urandom;
          cz = $urandom;
        end else begin
          cx = near(base[b], 32'h0008_0000);
          cy = near(base[b], 32'h0008_0000);
          cz = near(base[b], 32'h0008_0000);
        end
        add_insert(cx, cy, cz, nid, drain);
      end else begin
        roll = $urandom_range(0, 9);
        pick = $urandom_range(0, placed_x.size() - 1);
        if (roll <= 4) begin
          add_query(near(placed_x[pick], 32'h0002_0000), near(placed_y[pick], 32'h0002_0000),
                    near(placed_z[pick], 32'h0002_0000),
                    aprq_pkg::HALF_BITS'($urandom_range(0, 32'h0006_0000)), drain);
        end else if (roll <= 6) begin
          add_query(near(base[b], 32'h0004_0000), near(base[b], 32'h0004_0000),
                    near(base[b], 32'h0004_0000),
                    aprq_pkg::HALF_BITS'($urandom_range(32'h0001_0000, 32'h0040_0000)),
                    drain);
        end else if (roll == 7) begin
          add_query($urandom, $urandom, $urandom,
                    aprq_pkg::HALF_BITS'(31'h7FFF_FFFF - $urandom_range(0, 16'hFFFF)),
                    drain);
        end else if (roll == 8) begin
          add_query($urandom, $urandom, $urandom, aprq_pkg::HALF_BITS'($urandom), drain);
        end else begin
          add_query(placed_x[pick], placed_y[pick], placed_z[pick],
                    aprq_pkg::HALF_BITS'($urandom_range(0, 3)), drain);
        end
      end
    end
    item_total = commands_to_send.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count != item_total) @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
